/* hdl/swt_pkg.sv */
`default_nettype none

package swt_pkg;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChLf      = 8'd10;
  localparam logic [7:0] ChCr      = 8'd13;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChDquote  = 8'd34;
  localparam logic [7:0] ChSquote  = 8'd39;
  localparam logic [7:0] ChBslash  = 8'd92;
  localparam logic [7:0] ChHighAsc = 8'd127;
  localparam logic [7:0] ChLt      = 8'd60;
  localparam logic [7:0] ChEq      = 8'd61;
  localparam logic [7:0] ChGt      = 8'd62;
  localparam logic [7:0] ChBang    = 8'd33;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_TOKEND = 2'd1,
    KIND_EOT    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       lit;
  } res_t;

  // All results caused by one accepted byte, in emission order from index 0.
  typedef struct packed {
    logic [ResCntW-1:0]   cnt;
    res_t [MaxRes-1:0]    res;
  } bundle_t;

endpackage

`default_nettype wire

/* hdl/swt_front.sv */
`default_nettype none

module swt_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       char_code_i,
  input  wire logic             end_of_text_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output swt_pkg::bundle_t      q_data_o
);
  import swt_pkg::*;

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_WORD   = 6'b000010,
    M_LIT    = 6'b000100,
    M_LIT_BS = 6'b001000,
    M_LIT_SQ = 6'b010000,
    M_OP     = 6'b100000
  } mode_e;

  mode_e   mode_q, mode_d;
  bundle_t bund;
  logic    accept;

  function automatic bundle_t put(bundle_t b, kind_e k, logic [7:0] c, logic l);
    bundle_t r;
    r = b;
    if (r.cnt != ResCntW'(MaxRes)) begin
      r.res[r.cnt[1:0]] = '{kind: k, ch: c, lit: l};
      r.cnt = r.cnt + ResCntW'(1);
    end
    return r;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "." || c == "+" || c == "-" ||
           c == "_" || c == "*" || c > ChHighAsc;
  endfunction

  function automatic logic is_cmp_tail(logic [7:0] c);
    return c == ChLt || c == ChGt || c == ChEq;
  endfunction

  function automatic mode_e idle_byte(inout bundle_t b, input logic [7:0] c);
    mode_e m;
    m = M_IDLE;
    if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) begin
      m = M_IDLE;
    end else if (c == ChDquote || c == ChSquote) begin
      m = M_LIT;
    end else if (is_word(c)) begin
      m = M_WORD;
      b = put(b, KIND_CHAR, c, 1'b0);
    end else begin
      b = put(b, KIND_CHAR, c, 1'b0);
      if (is_cmp_tail(c) || c == ChBang) begin
        m = M_OP;
      end else begin
        b = put(b, KIND_TOKEND, 8'd0, 1'b0);
      end
    end
    return m;
  endfunction

  function automatic mode_e lit_byte(inout bundle_t b, input logic [7:0] c);
    mode_e m;
    m = M_LIT;
    if (c == ChBslash) begin
      m = M_LIT_BS;
    end else if (c == ChSquote) begin
      m = M_LIT_SQ;
    end else if (c == ChDquote) begin
      m = M_IDLE;
      b = put(b, KIND_TOKEND, 8'd0, 1'b1);
    end else begin
      b = put(b, KIND_CHAR, c, 1'b1);
    end
    return m;
  endfunction

  always_comb begin
    bund   = '0;
    mode_d = mode_q;
    if (end_of_text_i) begin
      unique case (mode_q)
        M_LIT_BS: begin
          bund = put(bund, KIND_CHAR, ChBslash, 1'b1);
          bund = put(bund, KIND_TOKEND, 8'd0, 1'b1);
        end
        M_LIT, M_LIT_SQ: bund = put(bund, KIND_TOKEND, 8'd0, 1'b1);
        M_WORD, M_OP:    bund = put(bund, KIND_TOKEND, 8'd0, 1'b0);
        default: ;
      endcase
      bund   = put(bund, KIND_EOT, 8'd0, 1'b0);
      mode_d = M_IDLE;
    end else begin
      unique case (mode_q)
        M_WORD: begin
          if (is_word(char_code_i)) begin
            bund = put(bund, KIND_CHAR, char_code_i, 1'b0);
          end else begin
            bund   = put(bund, KIND_TOKEND, 8'd0, 1'b0);
            mode_d = idle_byte(bund, char_code_i);
          end
        end
        M_LIT: mode_d = lit_byte(bund, char_code_i);
        M_LIT_BS: begin
          // escaped quote of either kind; anything else keeps the backslash
          if (char_code_i == ChDquote || char_code_i == ChSquote) begin
            bund   = put(bund, KIND_CHAR, char_code_i, 1'b1);
            mode_d = M_LIT;
          end else begin
            bund   = put(bund, KIND_CHAR, ChBslash, 1'b1);
            mode_d = lit_byte(bund, char_code_i);
          end
        end
        M_LIT_SQ: begin
          if (char_code_i == ChSquote) begin
            bund   = put(bund, KIND_CHAR, char_code_i, 1'b1);
            mode_d = M_LIT;
          end else begin
            bund   = put(bund, KIND_TOKEND, 8'd0, 1'b1);
            mode_d = idle_byte(bund, char_code_i);
          end
        end
        M_OP: begin
          if (is_cmp_tail(char_code_i)) begin
            bund   = put(bund, KIND_CHAR, char_code_i, 1'b0);
            bund   = put(bund, KIND_TOKEND, 8'd0, 1'b0);
            mode_d = M_IDLE;
          end else begin
            bund   = put(bund, KIND_TOKEND, 8'd0, 1'b0);
            mode_d = idle_byte(bund, char_code_i);
          end
        end
        default: mode_d = idle_byte(bund, char_code_i);
      endcase
    end
  end

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept && (bund.cnt != '0);
  assign q_data_o   = bund;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/swt_fifo.sv */
`default_nettype none

module swt_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire swt_pkg::bundle_t  data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output swt_pkg::bundle_t       data_o
);
  import swt_pkg::*;

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]    cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/swt_back.sv */
`default_nettype none

module swt_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire swt_pkg::bundle_t  q_data_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             out_char_o,
  output logic                   quoted_o,
  output logic                   last_o
);
  import swt_pkg::*;

  bundle_t            cur_q;
  logic [1:0]         idx_q;
  logic [ResCntW-1:0] rem_q;
  logic               out_vld_q;
  res_t               out_q;
  logic               last_q;
  logic               slot_free;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign q_pop_o   = slot_free && (rem_q == '0) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      rem_q     <= '0;
      idx_q     <= '0;
    end else if (slot_free) begin
      if (rem_q != '0) begin
        out_vld_q <= 1'b1;
        idx_q     <= idx_q + 2'd1;
        rem_q     <= rem_q - ResCntW'(1);
      end else if (q_valid_i) begin
        out_vld_q <= 1'b1;
        idx_q     <= 2'd1;
        rem_q     <= q_data_i.cnt - ResCntW'(1);
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (rem_q != '0) begin
        out_q  <= cur_q.res[idx_q];
        last_q <= (rem_q == ResCntW'(1));
      end else if (q_valid_i) begin
        cur_q  <= q_data_i;
        out_q  <= q_data_i.res[0];
        last_q <= (q_data_i.cnt == ResCntW'(1));
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_q.kind;
  assign out_char_o  = out_q.ch;
  assign quoted_o    = out_q.lit;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* hdl/sql_where_tokenizer.sv */
`default_nettype none

// WHERE-clause lexer. Takes one text byte per cycle (end_of_text marks the
// end of the clause) and emits token characters, end-of-token and
// end-of-text markers, each with a quoted-literal flag and a last flag on the
// final result of its byte. A byte is accepted in any cycle where the 4-entry
// result queue is not full; each byte yields 0 to 3 results, which the
// output stage delivers one per cycle while out_stall is low. The output
// stage's one result per cycle therefore sets the sustained rate: one byte
// per cycle while bytes average at most one result, with bursts of up to
// three absorbed by the queue. A byte's results enter the queue when it is
// accepted and are then registered one by one into the output stage.
module sql_where_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_char_o,
  output logic             quoted_o,
  output logic             last_o
);
  import swt_pkg::*;

  logic    q_push, q_full, q_valid, q_pop;
  bundle_t q_wdata, q_rdata;

  swt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  swt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  swt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .quoted_o    (quoted_o),
    .last_o      (last_o)
  );

  // a full queue must never take a request
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("push into full queue");

  // every queued bundle carries at least one result
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_wdata.cnt != '0))
    else $error("empty bundle queued");

  // markers carry no character; end of text closes the byte's results
  a_marker_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EOT) |-> last_o && !quoted_o && (out_char_o == 8'd0))
    else $error("bad end-of-text result");

endmodule

`default_nettype wire

/* tb/sql_where_tokenizer_tb.sv */
`default_nettype none

module sql_where_tokenizer_tb;
  import swt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 12;

  typedef enum logic [2:0] {
    LX_IDLE   = 3'd0,
    LX_WORD   = 3'd1,
    LX_LIT    = 3'd2,
    LX_LIT_BS = 3'd3,
    LX_LIT_SQ = 3'd4,
    LX_OP     = 3'd5
  } lex_mode_e;

  typedef struct {
    kind_e      kind;
    logic [7:0] ch;
    logic       lit;
    logic       last;
  } tok_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] char_code = 8'd0;
  logic       end_of_text = 1'b0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [1:0] kind;
  wire  [7:0] out_char;
  wire        quoted;
  wire        last;

  tok_res_t  tok_expect_q[$];
  tok_res_t  byte_res[$];
  lex_mode_e lex_mode = LX_IDLE;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_left = 0;

  sql_where_tokenizer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_code_i  (char_code),
    .end_of_text_i(end_of_text),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .out_char_o   (out_char),
    .quoted_o     (quoted),
    .last_o       (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- token predictor ----------------

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "." || c == "+" || c == "-" || c == "_" || c == "*" || c > ChHighAsc;
  endfunction

  function automatic void emit_res(kind_e k, logic [7:0] c, logic l);
    tok_res_t r;
    r.kind = k;
    r.ch = c;
    r.lit = l;
    r.last = 1'b0;
    byte_res.insert(byte_res.size(), r);
  endfunction

  function automatic void between_tokens(logic [7:0] c);
    lex_mode = LX_IDLE;
    if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) begin
      return;
    end
    if (c == ChDquote || c == ChSquote) begin
      lex_mode = LX_LIT;
    end else if (is_word_char(c)) begin
      lex_mode = LX_WORD;
      emit_res(KIND_CHAR, c, 1'b0);
    end else begin
      emit_res(KIND_CHAR, c, 1'b0);
      if (c == ChLt || c == ChGt || c == ChEq || c == ChBang) lex_mode = LX_OP;
      else emit_res(KIND_TOKEND, 8'd0, 1'b0);
    end
  endfunction

  function automatic void in_literal(logic [7:0] c);
    lex_mode = LX_LIT;
    if (c == ChBslash) begin
      lex_mode = LX_LIT_BS;
    end else if (c == ChSquote) begin
      lex_mode = LX_LIT_SQ;
    end else if (c == ChDquote) begin
      lex_mode = LX_IDLE;
      emit_res(KIND_TOKEND, 8'd0, 1'b1);
    end else begin
      emit_res(KIND_CHAR, c, 1'b1);
    end
  endfunction

  function automatic void lex_predict(logic [7:0] c, logic eot);
    byte_res.delete();
    if (eot) begin
      case (lex_mode)
        LX_LIT_BS: begin
          emit_res(KIND_CHAR, ChBslash, 1'b1);
          emit_res(KIND_TOKEND, 8'd0, 1'b1);
        end
        LX_LIT, LX_LIT_SQ: emit_res(KIND_TOKEND, 8'd0, 1'b1);
        LX_WORD, LX_OP: emit_res(KIND_TOKEND, 8'd0, 1'b0);
        default: ;
      endcase
      emit_res(KIND_EOT, 8'd0, 1'b0);
      lex_mode = LX_IDLE;
    end else begin
      case (lex_mode)
        LX_WORD: begin
          if (is_word_char(c)) begin
            emit_res(KIND_CHAR, c, 1'b0);
          end else begin
            emit_res(KIND_TOKEND, 8'd0, 1'b0);
            between_tokens(c);
          end
        end
        LX_LIT: in_literal(c);
        LX_LIT_BS: begin
          if (c == ChDquote || c == ChSquote) begin
            emit_res(KIND_CHAR, c, 1'b1);
            lex_mode = LX_LIT;
          end else begin
            emit_res(KIND_CHAR, ChBslash, 1'b1);
            in_literal(c);
          end
        end
        LX_LIT_SQ: begin
          if (c == ChSquote) begin
            emit_res(KIND_CHAR, c, 1'b1);
            lex_mode = LX_LIT;
          end else begin
            emit_res(KIND_TOKEND, 8'd0, 1'b1);
            between_tokens(c);
          end
        end
        LX_OP: begin
          if (c == ChLt || c == ChGt || c == ChEq) begin
            emit_res(KIND_CHAR, c, 1'b0);
            emit_res(KIND_TOKEND, 8'd0, 1'b0);
            lex_mode = LX_IDLE;
          end else begin
            emit_res(KIND_TOKEND, 8'd0, 1'b0);
            between_tokens(c);
          end
        end
        default: between_tokens(c);
      endcase
    end
    if (byte_res.size() > 0) byte_res[byte_res.size() - 1].last = 1'b1;
    foreach (byte_res[i]) tok_expect_q.insert(tok_expect_q.size(), byte_res[i]);
  endfunction

  // ---------------- request side ----------------

  task automatic send_byte(logic [7:0] c, logic eot);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_predict(c, eot);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tok_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_char();
    string punct = ".+-_*";
    case ($urandom_range(0, 5))
      0: return 8'("A" + $urandom_range(0, 25));
      1: return 8'("0" + $urandom_range(0, 9));
      2: return punct[$urandom_range(0, 4)];
      3: return 8'(8'd128 + $urandom_range(0, 127));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return ChTab;
      1: return ChLf;
      2: return ChCr;
      default: return ChSpace;
    endcase
  endfunction

  function automatic logic [7:0] rand_cmp();
    case ($urandom_range(0, 3))
      0: return ChLt;
      1: return ChGt;
      2: return ChEq;
      default: return ChBang;
    endcase
  endfunction

  // Mostly well-formed clause pieces with random content; some raw noise.
  task automatic send_random_text(int n_items);
    logic [7:0] txt[$];
    logic [7:0] q;
    string      syms = "(),;%/";
    int         sent;
    sent = 0;
    while (sent < n_items) begin
      txt.delete();
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 2)) txt.insert(txt.size(), rand_blank());
        end
        2, 3: begin
          repeat ($urandom_range(1, 6)) txt.insert(txt.size(), rand_word_char());
        end
        4, 5: begin
          q = $urandom_range(0, 1) ? ChDquote : ChSquote;
          txt.insert(txt.size(), q);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
              0: begin
                txt.insert(txt.size(), ChBslash);
                txt.insert(txt.size(), $urandom_range(0, 1) ? ChDquote : ChSquote);
              end
              1: begin
                txt.insert(txt.size(), ChBslash);
                txt.insert(txt.size(), rand_word_char());
              end
              2: begin
                txt.insert(txt.size(), ChSquote);
                txt.insert(txt.size(), ChSquote);
              end
              3: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
              default: txt.insert(txt.size(), rand_word_char());
            endcase
          end
          if ($urandom_range(0, 99) < 85) txt.insert(txt.size(), q);
        end
        6: begin
          txt.insert(txt.size(), rand_cmp());
          if ($urandom_range(0, 1)) txt.insert(txt.size(), rand_cmp());
        end
        7: txt.insert(txt.size(), syms[$urandom_range(0, 5)]);
        default: begin
          repeat ($urandom_range(1, 3)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
      endcase
      foreach (txt[i]) send_byte(txt[i], 1'b0);
      sent += txt.size();
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
    end
  endtask

  // ---------------- response side ----------------

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    tok_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tok_expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result kind %0d char %02h lit %0b last %0b",
                 $time, kind, out_char, quoted, last);
      end else begin
        want = tok_expect_q.pop_front();
        if (kind !== want.kind || out_char !== want.ch || quoted !== want.lit ||
            last !== want.last) begin
          err_cnt++;
          $display("%0t: expected kind %0d char %02h lit %0b last %0b, got %0d %02h %0b %0b",
                   $time, want.kind, want.ch, want.lit, want.last,
                   kind, out_char, quoted, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("sql_where_tokenizer_tb: errors");
      $finish;
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_byte(ChSpace, 1'b0);
    send_byte(ChTab, 1'b0);
    send_byte(8'hFF, 1'b0);
    // operator pair, operator head alone, backslash before a plain byte,
    // doubled single quote, escaped double quote
    send_text("a<=!x'\\b''\\\"'");
    // pending single quote closed by a NUL, which is a token of its own
    send_byte(8'h00, 1'b0);
    send_text("\"\"");  // empty literal
    send_text(">>=");
    send_byte(8'h00, 1'b1);  // operator head open at end of text
    send_text("\"\\");
    send_byte(8'hFF, 1'b1);  // backslash pending at end of text
    send_byte(8'h00, 1'b1);  // end of text with nothing open
    wait_drained();
  endtask

  task automatic test_random_phases();
    idle_pct = 0;  stall_pct = 0;  send_random_text(55);
    idle_pct = 68; stall_pct = 0;  send_random_text(55);
    idle_pct = 0;  stall_pct = 68; send_random_text(55);
    idle_pct = 28; stall_pct = 28; send_random_text(55);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 80;
    send_random_text(20);
    wait_drained();
    stall_pct = 28;
    send_random_text(10);
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    stall_pct = 0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("sql_where_tokenizer_tb: clean");
    end else begin
      $display("sql_where_tokenizer_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
